@@ rtl/core/drt_pkg.sv @@
// shared constants, types and field widths for the difficulty retarget block
package drt_pkg;

  localparam int unsigned CUR_W   = 32;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned HGT_W   = 32;
  localparam int unsigned BTT_W   = 16;
  localparam int unsigned EXP_W   = 32;   // expected window time
  localparam int unsigned CLMP_W  = 34;   // clamped time, at most four times expected
  localparam int unsigned MANT_W  = 24;
  localparam int unsigned PROD_W  = MANT_W + CLMP_W;
  localparam int unsigned QUO_W   = 26;   // quotient is at most four times the mantissa
  localparam int unsigned M_W     = 23;
  localparam int unsigned CFG_A_W = 2;
  localparam int unsigned CFG_D_W = 32;

  localparam logic [M_W-1:0] MANT_MAX = 23'h7fffff;

  localparam logic [BTT_W-1:0] BTT_RST = 16'd600;
  localparam logic [HGT_W-1:0] EPH_RST = 32'd10000;

  localparam logic [CFG_A_W-1:0] CFG_BTT = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_EPH = 2'd1;

  typedef struct packed {
    logic             bypass;
    logic [CUR_W-1:0] cur;
    logic             lt8;
    logic             gt8;
    logic             dbl;
    logic             hlv;
  } side_t;

endpackage

@@ rtl/core/drt_front.sv @@
// front stages: window time, expected time, clamp and mantissa product
module drt_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [drt_pkg::BTT_W-1:0] btt,
  input  logic [drt_pkg::HGT_W-1:0] eph,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [drt_pkg::CUR_W-1:0] in_cur,
  input  logic [drt_pkg::TIME_W-1:0] in_last,
  input  logic [drt_pkg::TIME_W-1:0] in_first,
  input  logic [drt_pkg::CNT_W-1:0] in_count,
  input  logic [drt_pkg::HGT_W-1:0] in_height,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [drt_pkg::PROD_W-1:0] out_prod,
  output logic [drt_pkg::EXP_W-1:0] out_den,
  output drt_pkg::side_t            out_side
);
  import drt_pkg::*;

  logic                v1_r, v2_r, v3_r;
  logic                rdy1, rdy2, rdy3;
  logic [CUR_W-1:0]    cur1_r;
  logic [TIME_W-1:0]   el1_r;
  logic [EXP_W-1:0]    exp1_r, exp2_r, exp3_r;
  logic                byp1_r, hl1_r;
  logic [CLMP_W-1:0]   clmp2_r;
  side_t               side2_r, side3_r, side2_nxt;
  logic [PROD_W-1:0]   prod3_r;
  logic [CNT_W-1:0]    cnt_m1;
  logic [TIME_W-1:0]   e64, qtr, fourx, eighth, eightx, half, twox;
  logic [CLMP_W-1:0]   clmp_nxt;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign cnt_m1 = in_count - CNT_W'(1);

  // stage 2 comparisons against the unclamped time
  assign e64    = TIME_W'(exp1_r);
  assign qtr    = e64 >> 2;
  assign fourx  = e64 << 2;
  assign eighth = e64 >> 3;
  assign eightx = e64 << 3;
  assign half   = e64 >> 1;
  assign twox   = e64 << 1;

  always_comb begin
    if (el1_r < qtr) begin
      clmp_nxt = CLMP_W'(qtr);
    end else if (el1_r > fourx) begin
      clmp_nxt = CLMP_W'(fourx);
    end else begin
      clmp_nxt = el1_r[CLMP_W-1:0];
    end
    side2_nxt.bypass = byp1_r || (exp1_r == '0);
    side2_nxt.cur    = cur1_r;
    side2_nxt.lt8    = el1_r < eighth;
    side2_nxt.gt8    = el1_r > eightx;
    side2_nxt.dbl    = hl1_r && (el1_r < half);
    side2_nxt.hlv    = hl1_r && (el1_r > twox);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
    if (rdy1 && in_valid) begin
      cur1_r <= in_cur;
      el1_r  <= in_last - in_first;
      exp1_r <= EXP_W'(btt) * EXP_W'(cnt_m1);
      byp1_r <= (in_count < CNT_W'(2)) || (in_last <= in_first);
      hl1_r  <= in_height < eph;
    end
    if (rdy2 && v1_r) begin
      clmp2_r <= clmp_nxt;
      side2_r <= side2_nxt;
      exp2_r  <= exp1_r;
    end
    if (rdy3 && v2_r) begin
      prod3_r <= PROD_W'(side2_r.cur[MANT_W-1:0]) * PROD_W'(clmp2_r);
      side3_r <= side2_r;
      exp3_r  <= exp2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_prod  = prod3_r;
  assign out_den   = exp3_r;
  assign out_side  = side3_r;

endmodule

@@ rtl/core/drt_div_stage.sv @@
// one restoring division step with its pipeline register
module drt_div_stage #(
  parameter int unsigned SHIFT = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [drt_pkg::PROD_W-1:0] in_rem,
  input  logic [drt_pkg::QUO_W-1:0]  in_quo,
  input  logic [drt_pkg::EXP_W-1:0]  in_den,
  input  drt_pkg::side_t             in_side,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [drt_pkg::PROD_W-1:0] out_rem,
  output logic [drt_pkg::QUO_W-1:0]  out_quo,
  output logic [drt_pkg::EXP_W-1:0]  out_den,
  output drt_pkg::side_t             out_side
);
  import drt_pkg::*;

  logic              v_r;
  logic [PROD_W-1:0] rem_r, den_sh;
  logic [QUO_W-1:0]  quo_r;
  logic [EXP_W-1:0]  den_r;
  side_t             side_r;
  logic              ge;

  assign in_ready = !v_r || out_ready;
  assign den_sh   = PROD_W'(in_den) << SHIFT;
  assign ge       = in_rem >= den_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      rem_r  <= ge ? (in_rem - den_sh) : in_rem;
      quo_r  <= in_quo | (QUO_W'(ge) << SHIFT);
      den_r  <= in_den;
      side_r <= in_side;
    end
  end

  assign out_valid = v_r;
  assign out_rem   = rem_r;
  assign out_quo   = quo_r;
  assign out_den   = den_r;
  assign out_side  = side_r;

endmodule

@@ rtl/core/difficulty_retarget.sv @@
// top level: config registers, front stages, divider chain and final adjust
//
//  channel | ports                        | handshake
//  in      | in_current_target .. height  | in_valid / in_ready
//  out     | out_next_target              | out_valid / out_ready
//  cfg     | cfg_addr, cfg_wdata          | cfg_we, no wait
//
// one word enters per cycle unless out_ready stalls the pipe; three front stages,
// one stage per quotient bit of the restoring divider (26), one adjust stage.
// reset clears all valid bits and loads the default config.
// a stall at out_ready backs up stage by stage; bubbles are squeezed out.
module difficulty_retarget (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [drt_pkg::CUR_W-1:0]    in_current_target,
  input  logic [drt_pkg::TIME_W-1:0]   in_last_block_time,
  input  logic [drt_pkg::TIME_W-1:0]   in_first_block_time,
  input  logic [drt_pkg::CNT_W-1:0]    in_block_count,
  input  logic [drt_pkg::HGT_W-1:0]    in_chain_height,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [drt_pkg::CUR_W-1:0]    out_next_target,
  input  logic                         cfg_we,
  input  logic [drt_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [drt_pkg::CFG_D_W-1:0]  cfg_wdata
);
  import drt_pkg::*;

  logic [BTT_W-1:0]  btt_r;
  logic [HGT_W-1:0]  eph_r;

  logic              d_v   [QUO_W+1];
  logic              d_rdy [QUO_W+1];
  logic [PROD_W-1:0] d_rem [QUO_W+1];
  logic [QUO_W-1:0]  d_quo [QUO_W+1];
  logic [EXP_W-1:0]  d_den [QUO_W+1];
  side_t             d_side[QUO_W+1];

  logic              out_valid_r, byp_r, fin_rdy;
  logic [CUR_W-1:0]  next_target_r, tgt_nxt;
  logic [M_W-1:0]    m0, m1, m2;
  logic [M_W+1:0]    m4;
  logic [M_W:0]      m2x;
  side_t             fs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      btt_r <= BTT_RST;
      eph_r <= EPH_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_BTT: btt_r <= cfg_wdata[BTT_W-1:0];
        CFG_EPH: eph_r <= cfg_wdata[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  drt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .btt       (btt_r),
    .eph       (eph_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cur    (in_current_target),
    .in_last   (in_last_block_time),
    .in_first  (in_first_block_time),
    .in_count  (in_block_count),
    .in_height (in_chain_height),
    .out_valid (d_v[0]),
    .out_ready (d_rdy[0]),
    .out_prod  (d_rem[0]),
    .out_den   (d_den[0]),
    .out_side  (d_side[0])
  );
  assign d_quo[0] = '0;

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    drt_div_stage #(.SHIFT(QUO_W - 1 - k)) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (d_v[k]),
      .in_ready  (d_rdy[k]),
      .in_rem    (d_rem[k]),
      .in_quo    (d_quo[k]),
      .in_den    (d_den[k]),
      .in_side   (d_side[k]),
      .out_valid (d_v[k+1]),
      .out_ready (d_rdy[k+1]),
      .out_rem   (d_rem[k+1]),
      .out_quo   (d_quo[k+1]),
      .out_den   (d_den[k+1]),
      .out_side  (d_side[k+1])
    );
  end

  // final adjust: saturate, emergency rule, early-height rule, or bypass to the current target
  assign fs      = d_side[QUO_W];
  assign fin_rdy = !out_valid_r || out_ready;
  assign d_rdy[QUO_W] = fin_rdy;

  always_comb begin
    m0  = (d_quo[QUO_W] > QUO_W'(MANT_MAX)) ? MANT_MAX : d_quo[QUO_W][M_W-1:0];
    m4  = {m0, 2'b00};
    m1  = m0;
    if (fs.lt8) begin
      m1 = (m4 > (M_W+2)'(MANT_MAX)) ? MANT_MAX : m4[M_W-1:0];
    end else if (fs.gt8) begin
      m1 = m0 >> 2;
    end
    m2x = {m1, 1'b0};
    m2  = m1;
    if (fs.dbl) begin
      m2 = (m2x > (M_W+1)'(MANT_MAX)) ? MANT_MAX : m2x[M_W-1:0];
    end else if (fs.hlv) begin
      m2 = m1 >> 1;
    end
    tgt_nxt = fs.bypass ? fs.cur : {fs.cur[CUR_W-1:MANT_W], 1'b0, m2};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_rdy) begin
      out_valid_r <= d_v[QUO_W];
    end
    if (fin_rdy && d_v[QUO_W]) begin
      next_target_r <= tgt_nxt;
      byp_r         <= fs.bypass;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_next_target = next_target_r;

`ifndef SYNTH
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("output valid set after reset");
  a_mant_top_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !byp_r |-> next_target_r[MANT_W-1] == 1'b0)
    else $error("adjusted mantissa above saturation limit");
  a_rules_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    d_v[QUO_W] && !fs.bypass |-> !(fs.lt8 && fs.gt8) && !(fs.dbl && fs.hlv))
    else $error("conflicting adjust rules");
`endif

endmodule
